// File: hw/rtl/slht_pkg.sv
package slht_pkg;

    // Default geometry
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int TIME_FRAC_BITS_DEF = 20;

    // Fixed field widths
    localparam int ANG_W  = 15;     // heading, 1/64 degree
    localparam int RATE_W = 16;     // turn rate register

    // CORDIC angle accumulator, 2^-16 degree
    localparam int ZW       = 26;
    localparam int ANG_FRAC = 10;   // 2^-16 -> 2^-6 degree

    // Angle constants in 1/64 degree
    localparam int HALF_TURN = 11520;
    localparam int FULL_TURN = 23040;

    localparam logic signed [ZW-1:0] QUARTER_FINE = ZW'(5898240);
    localparam logic [RATE_W-1:0]    TURN_RATE_RESET = RATE_W'(16640);

    // Side data that travels with an item through the CORDIC pipe
    typedef struct packed {
        logic [RATE_W-1:0] step;    // whole part of rate * time
        logic              frac_nz; // fractional part of rate * time is nonzero
        logic              is_zero; // pointer on body
        logic              is_left; // pointer straight left
    } slht_side_t;

    // Enables for the two stages of the heading update
    typedef struct packed {
        logic load_tgt;
        logic take;
    } slht_upd_ctrl_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ZW-1:0] atan_fine(input int unsigned idx);
        case (idx)
            0:       return ZW'(2949120);
            1:       return ZW'(1740967);
            2:       return ZW'(919879);
            3:       return ZW'(466945);
            4:       return ZW'(234379);
            5:       return ZW'(117304);
            6:       return ZW'(58666);
            7:       return ZW'(29335);
            8:       return ZW'(14668);
            9:       return ZW'(7334);
            10:      return ZW'(3667);
            11:      return ZW'(1833);
            12:      return ZW'(917);
            13:      return ZW'(458);
            14:      return ZW'(229);
            15:      return ZW'(115);
            16:      return ZW'(57);
            17:      return ZW'(29);
            18:      return ZW'(14);
            19:      return ZW'(7);
            20:      return ZW'(4);
            21:      return ZW'(2);
            22:      return ZW'(1);
            default: return '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/slht_if.sv
// Input channel: positions and frame time
interface slht_in_if #(
    parameter int COORD_WIDTH    = slht_pkg::COORD_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = slht_pkg::TIME_FRAC_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] body_x;
    logic signed [COORD_WIDTH-1:0] body_y;
    logic signed [COORD_WIDTH-1:0] pointer_x;
    logic signed [COORD_WIDTH-1:0] pointer_y;
    logic [TIME_FRAC_BITS-1:0]     elapsed_time;

    modport source (
        output valid, body_x, body_y, pointer_x, pointer_y, elapsed_time,
        input  ready
    );
    modport sink (
        input  valid, body_x, body_y, pointer_x, pointer_y, elapsed_time,
        output ready
    );
endinterface

// Output channel: updated and target heading
interface slht_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [slht_pkg::ANG_W-1:0]  heading;
    logic signed [slht_pkg::ANG_W-1:0]  target_heading;

    modport source (
        output valid, heading, target_heading,
        input  ready
    );
    modport sink (
        input  valid, heading, target_heading,
        output ready
    );
endinterface

// File: hw/rtl/slew_limited_heading_tracker_core.sv
// Slew-limited heading tracker. Each input transfer carries a body and a
// pointer position plus a frame time; the block returns one result per item:
// the target heading atan2(dy, dx) and the kept heading moved toward it by at
// most turn_rate * elapsed_time, both in 1/64 degree wrapped to +/-180. The
// pipeline takes one item per clock while the output is not stalled; its stages are
// the input register, fold/multiply, one CORDIC rotation per stage, rounding and
// heading update; the heading update is the only feedback path. Bubbles
// collapse under output backpressure, so input is refused only when every stage
// is full and the result is not taken.
// turn_rate resets to 260 degrees per second and is written through cfg_we.
module slew_limited_heading_tracker_core #(
    parameter int COORD_WIDTH    = slht_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES  = slht_pkg::CORDIC_STAGES_DEF,
    parameter int TIME_FRAC_BITS = slht_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    slht_in_if.sink                      in_ch,
    slht_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic [slht_pkg::RATE_W-1:0]  cfg_wdata
);
    localparam int XW  = COORD_WIDTH + CORDIC_STAGES + 3;
    localparam int NST = CORDIC_STAGES + 4;
    localparam int TGT = CORDIC_STAGES + 2;   // rounding stage
    localparam int OUT = CORDIC_STAGES + 3;   // result stage

    logic [slht_pkg::RATE_W-1:0]     turn_rate_reg;
    logic [NST-1:0]                  v_reg, v_next, can_load;

    logic signed [XW-1:0]            x_pipe [0:CORDIC_STAGES];
    logic signed [XW-1:0]            y_pipe [0:CORDIC_STAGES];
    logic signed [slht_pkg::ZW-1:0]  z_pipe [0:CORDIC_STAGES];
    slht_pkg::slht_side_t            side_pipe [0:CORDIC_STAGES];
    slht_pkg::slht_upd_ctrl_t        upd_ctrl;

    // Turn rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            turn_rate_reg <= slht_pkg::TURN_RATE_RESET;
        else if (cfg_we)
            turn_rate_reg <= cfg_wdata;
    end

    // A stage loads when it is empty or its item moves on
    always_comb
    begin
        can_load[NST-1] = !v_reg[NST-1] || out_ch.ready;
        for (int i = NST - 2; i >= 0; i--)
            can_load[i] = !v_reg[i] || can_load[i+1];
    end

    always_comb
    begin
        v_next[0] = can_load[0] ? in_ch.valid : v_reg[0];
        for (int i = 1; i < NST; i++)
            v_next[i] = can_load[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ch.ready  = can_load[0];
    assign out_ch.valid = v_reg[OUT];

    // Input register, differences, quadrant fold, rate * time
    slht_front #(
        .COORD_WIDTH    (COORD_WIDTH),
        .CORDIC_STAGES  (CORDIC_STAGES),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .load_in      (can_load[0]),
        .load_pre     (can_load[1]),
        .body_x       (in_ch.body_x),
        .body_y       (in_ch.body_y),
        .pointer_x    (in_ch.pointer_x),
        .pointer_y    (in_ch.pointer_y),
        .elapsed_time (in_ch.elapsed_time),
        .turn_rate    (turn_rate_reg),
        .x            (x_pipe[0]),
        .y            (y_pipe[0]),
        .z            (z_pipe[0]),
        .side         (side_pipe[0])
    );

    // CORDIC vectoring pipe, one rotation per stage
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        slht_cordic_stage #(
            .COORD_WIDTH   (COORD_WIDTH),
            .CORDIC_STAGES (CORDIC_STAGES),
            .IDX           (k)
        ) u_stage (
            .clk     (clk),
            .load    (can_load[k+2]),
            .x_in    (x_pipe[k]),
            .y_in    (y_pipe[k]),
            .z_in    (z_pipe[k]),
            .side_in (side_pipe[k]),
            .x       (x_pipe[k+1]),
            .y       (y_pipe[k+1]),
            .z       (z_pipe[k+1]),
            .side    (side_pipe[k+1])
        );
    end

    // Heading update commits only on a real item
    always_comb
    begin
        upd_ctrl.load_tgt = can_load[TGT];
        upd_ctrl.take     = can_load[OUT] && v_reg[TGT];
    end

    slht_update u_update (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (upd_ctrl),
        .z_in           (z_pipe[CORDIC_STAGES]),
        .side_in        (side_pipe[CORDIC_STAGES]),
        .heading        (out_ch.heading),
        .target_heading (out_ch.target_heading)
    );

    // Final x and y are unused; only z carries the angle
    logic unused_x;
    assign unused_x = ^x_pipe[CORDIC_STAGES] ^ ^y_pipe[CORDIC_STAGES];

endmodule

// File: hw/rtl/slht_front.sv
module slht_front #(
    parameter int COORD_WIDTH    = slht_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES  = slht_pkg::CORDIC_STAGES_DEF,
    parameter int TIME_FRAC_BITS = slht_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         load_in,
    input  logic                                         load_pre,
    input  logic signed [COORD_WIDTH-1:0]                body_x,
    input  logic signed [COORD_WIDTH-1:0]                body_y,
    input  logic signed [COORD_WIDTH-1:0]                pointer_x,
    input  logic signed [COORD_WIDTH-1:0]                pointer_y,
    input  logic [TIME_FRAC_BITS-1:0]                    elapsed_time,
    input  logic [slht_pkg::RATE_W-1:0]                  turn_rate,
    output logic signed [COORD_WIDTH+CORDIC_STAGES+2:0]  x,
    output logic signed [COORD_WIDTH+CORDIC_STAGES+2:0]  y,
    output logic signed [slht_pkg::ZW-1:0]               z,
    output slht_pkg::slht_side_t                         side
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = COORD_WIDTH + CORDIC_STAGES + 3;
    localparam int PW = slht_pkg::RATE_W + TIME_FRAC_BITS;

    logic signed [COORD_WIDTH-1:0]   bx_reg, by_reg, px_reg, py_reg;
    logic [TIME_FRAC_BITS-1:0]       tm_reg;

    logic signed [DW-1:0]            dx, dy;
    logic signed [XW-1:0]            dx_s, dy_s;
    logic signed [XW-1:0]            x_next, y_next, x_reg, y_reg;
    logic signed [slht_pkg::ZW-1:0]  z_next, z_reg;
    logic [PW-1:0]                   prod;
    slht_pkg::slht_side_t            side_next, side_reg;

    // Input register
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            bx_reg <= body_x;
            by_reg <= body_y;
            px_reg <= pointer_x;
            py_reg <= pointer_y;
            tm_reg <= elapsed_time;
        end
    end

    // Differences, scaling and quadrant fold into the right half plane
    always_comb
    begin
        dx   = DW'(px_reg) - DW'(bx_reg);
        dy   = DW'(py_reg) - DW'(by_reg);
        dx_s = XW'(dx) <<< CORDIC_STAGES;
        dy_s = XW'(dy) <<< CORDIC_STAGES;
        if (dx_s < 0)
        begin
            if (dy_s >= 0)
            begin
                x_next = dy_s;
                y_next = -dx_s;
                z_next = slht_pkg::QUARTER_FINE;
            end
            else
            begin
                x_next = -dy_s;
                y_next = dx_s;
                z_next = -slht_pkg::QUARTER_FINE;
            end
        end
        else
        begin
            x_next = dx_s;
            y_next = dy_s;
            z_next = '0;
        end
    end

    // Turn step = rate * time, split into whole and fractional part
    always_comb
    begin
        prod              = PW'(turn_rate) * PW'(tm_reg);
        side_next.step    = prod[PW-1:TIME_FRAC_BITS];
        side_next.frac_nz = |prod[TIME_FRAC_BITS-1:0];
        side_next.is_zero = (dx == '0) && (dy == '0);
        side_next.is_left = (dy == '0) && dx[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (load_pre)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign side = side_reg;

endmodule

// File: hw/rtl/slht_cordic_stage.sv
module slht_cordic_stage #(
    parameter int COORD_WIDTH   = slht_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = slht_pkg::CORDIC_STAGES_DEF,
    parameter int IDX           = 0
) (
    input  logic                                         clk,
    input  logic                                         load,
    input  logic signed [COORD_WIDTH+CORDIC_STAGES+2:0]  x_in,
    input  logic signed [COORD_WIDTH+CORDIC_STAGES+2:0]  y_in,
    input  logic signed [slht_pkg::ZW-1:0]               z_in,
    input  slht_pkg::slht_side_t                         side_in,
    output logic signed [COORD_WIDTH+CORDIC_STAGES+2:0]  x,
    output logic signed [COORD_WIDTH+CORDIC_STAGES+2:0]  y,
    output logic signed [slht_pkg::ZW-1:0]               z,
    output slht_pkg::slht_side_t                         side
);
    localparam int XW = COORD_WIDTH + CORDIC_STAGES + 3;
    localparam logic signed [slht_pkg::ZW-1:0] ATAN = slht_pkg::atan_fine(IDX);

    logic signed [XW-1:0]            xs, ys;
    logic signed [XW-1:0]            x_next, y_next, x_reg, y_reg;
    logic signed [slht_pkg::ZW-1:0]  z_next, z_reg;
    slht_pkg::slht_side_t            side_reg;

    // One vectoring rotation: drive y toward zero
    always_comb
    begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (!y_in[XW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign side = side_reg;

endmodule

// File: hw/rtl/slht_update.sv
module slht_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  slht_pkg::slht_upd_ctrl_t           ctrl,
    input  logic signed [slht_pkg::ZW-1:0]     z_in,
    input  slht_pkg::slht_side_t               side_in,
    output logic signed [slht_pkg::ANG_W-1:0]  heading,
    output logic signed [slht_pkg::ANG_W-1:0]  target_heading
);
    localparam int AW = slht_pkg::ANG_W;
    localparam int RW = slht_pkg::ZW - slht_pkg::ANG_FRAC;
    localparam int RATE_W = slht_pkg::RATE_W;

    logic signed [slht_pkg::ZW-1:0]  zsum;
    logic signed [RW-1:0]            zr, zw;
    logic signed [AW-1:0]            tgt_next, tgt_reg;
    logic [RATE_W-1:0]               step_reg;
    logic                            frac_nz_reg;

    logic signed [AW:0]              diff_raw, diff;
    logic [AW:0]                     mag;
    logic signed [AW+1:0]            moved, moved_w;
    logic                            snap;
    logic signed [AW-1:0]            heading_next, heading_reg, target_out_reg;

    // Round to 1/64 degree, wrap once, apply the degenerate directions
    always_comb
    begin
        zsum = z_in + slht_pkg::ZW'(1 << (slht_pkg::ANG_FRAC - 1));
        zr   = RW'(zsum >>> slht_pkg::ANG_FRAC);
        if (zr > slht_pkg::HALF_TURN)
            zw = RW'(zr - slht_pkg::FULL_TURN);
        else if (zr < -slht_pkg::HALF_TURN)
            zw = RW'(zr + slht_pkg::FULL_TURN);
        else
            zw = zr;
        priority if (side_in.is_zero)
            tgt_next = '0;
        else if (side_in.is_left)
            tgt_next = AW'(-slht_pkg::HALF_TURN);
        else
            tgt_next = AW'(zw);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_tgt)
        begin
            tgt_reg     <= tgt_next;
            step_reg    <= side_in.step;
            frac_nz_reg <= side_in.frac_nz;
        end
    end

    // Slew-limited heading update: the one loop through the kept heading
    always_comb
    begin
        diff_raw = (AW+1)'(tgt_reg) - (AW+1)'(heading_reg);
        if (diff_raw > slht_pkg::HALF_TURN)
            diff = (AW+1)'(diff_raw - slht_pkg::FULL_TURN);
        else if (diff_raw < -slht_pkg::HALF_TURN)
            diff = (AW+1)'(diff_raw + slht_pkg::FULL_TURN);
        else
            diff = diff_raw;
        mag  = diff[AW] ? (AW+1)'(-diff) : (AW+1)'(diff);
        // |diff| * 2^F < step * 2^F + frac
        snap = ((AW+1)'(mag) < step_reg) || (((AW+1)'(mag) == step_reg) && frac_nz_reg);
        // step <= |diff| when not snapping, so one wrap suffices
        if (diff > 0)
            moved = (AW+2)'(heading_reg) + signed'({1'b0, step_reg});
        else
            moved = (AW+2)'(heading_reg) - signed'({1'b0, step_reg});
        if (moved > slht_pkg::HALF_TURN)
            moved_w = (AW+2)'(moved - slht_pkg::FULL_TURN);
        else if (moved < -slht_pkg::HALF_TURN)
            moved_w = (AW+2)'(moved + slht_pkg::FULL_TURN);
        else
            moved_w = moved;
        heading_next = snap ? tgt_reg : AW'(moved_w);
    end

    // Kept heading doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heading_reg <= '0;
        else if (ctrl.take)
            heading_reg <= heading_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
            target_out_reg <= tgt_reg;
    end

    assign heading        = heading_reg;
    assign target_heading = target_out_reg;

endmodule

// File: hw/rtl/slht_checker.sv
module slht_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [slht_pkg::ANG_W-1:0]  heading,
    input logic signed [slht_pkg::ANG_W-1:0]  target_heading
);
    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading)
            && $stable(target_heading))
        else $error("result changed while stalled");

    // Input is refused only behind a stalled result
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output backpressure");

    // Headings stay within plus or minus 180 degrees
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading >= -15'sd11520) && (heading <= 15'sd11520))
        else $error("heading out of range");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_heading >= -15'sd11520)
            && (target_heading <= 15'sd11520))
        else $error("target heading out of range");

endmodule

bind slew_limited_heading_tracker_core slht_checker u_slht_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .heading        (out_ch.heading),
    .target_heading (out_ch.target_heading)
);
